### sv/i2cm_pkg.sv
package i2cm_pkg;

	// command codes carried by the operation field
	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	localparam int unsigned PhaseIdxW = 5;
	localparam logic [PhaseIdxW-1:0] PhasesByte = PhaseIdxW'(19);
	localparam logic [PhaseIdxW-1:0] PhasesCond = PhaseIdxW'(3);

	localparam logic [7:0] PhaseTicksRst = 8'd5;

	typedef struct packed {
		cmd_t       op;
		logic [7:0] tx_byte;
		logic       read_ack;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
		logic       cmd_ignored;
	} res_t;

	function automatic logic is_cmd(cmd_t op);
		return (op == CMD_START) || (op == CMD_STOP) || (op == CMD_WRITE) ||
			(op == CMD_READ);
	endfunction

	function automatic logic [PhaseIdxW-1:0] phase_total(cmd_t cmd);
		return ((cmd == CMD_WRITE) || (cmd == CMD_READ)) ? PhasesByte : PhasesCond;
	endfunction

endpackage

### sv/i2c_master_byte_engine_top.sv
// Open-drain I2C byte engine. Each item beat is one timebase tick carrying the sampled SDA level
// and, when the engine is idle, an optional command (start, stop, write byte, read byte); every
// item yields exactly one result beat with the pin levels after that tick plus busy, done, the
// last read byte, the last write ACK and a flag for a command dropped while busy. Each bus phase
// is held phase_ticks ticks (APB register at address 0, reset 5, 0 behaves as 1), so a start or
// stop lasts 3 phases and a byte transfer 19. The item register feeds one pass of phase logic into
// the result register, so one item is taken per clock; each result beat is loaded into the result
// register from the item register, and the input stalls only when the result register is full and
// not being drained.
module i2c_master_byte_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  operation,
	input  logic [7:0]  tx_byte,
	input  logic        read_ack,
	input  logic        sda_in,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        scl_release,
	output logic        sda_release,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  rx_byte,
	output logic        ack_seen,
	output logic        cmd_ignored
);

	logic [7:0]      phase_ticks_q;
	i2cm_pkg::item_t item_s1;
	logic            valid_s1;
	i2cm_pkg::res_t  res_next, res_q;
	logic            res_valid_q;
	logic            adv;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {24'd0, phase_ticks_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cm_pkg::PhaseTicksRst;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			phase_ticks_q <= pwdata[7:0];
		end
	end

	// the item stage moves on whenever the result register is empty or being drained
	assign adv        = valid_s1 && (!res_valid_q || res_ready);
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1.op       <= i2cm_pkg::cmd_t'(operation);
			item_s1.tx_byte  <= tx_byte;
			item_s1.read_ack <= read_ack;
			item_s1.sda_in   <= sda_in;
		end
	end

	i2cm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.item        (item_s1),
		.phase_ticks (phase_ticks_q),
		.res         (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_q <= res_next;
	end

	assign res_valid   = res_valid_q;
	assign scl_release = res_q.scl_release;
	assign sda_release = res_q.sda_release;
	assign busy_res    = res_q.busy_res;
	assign done_res    = res_q.done_res;
	assign rx_byte     = res_q.rx_byte;
	assign ack_seen    = res_q.ack_seen;
	assign cmd_ignored = res_q.cmd_ignored;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.done_res && res_q.busy_res))
		else $error("result beat flags done while still busy");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled item stage lost or changed its beat");

	a_ignored_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_next.cmd_ignored) |-> (u_core.cmd_q != i2cm_pkg::CMD_NONE))
		else $error("command flagged as ignored while idle");

endmodule

### sv/i2cm_core.sv
module i2cm_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  i2cm_pkg::item_t   item,
	input  logic [7:0]        phase_ticks,
	output i2cm_pkg::res_t    res
);

	i2cm_pkg::cmd_t cmd_q, cmd_n;
	logic [i2cm_pkg::PhaseIdxW-1:0] pi_q, pi_n, pi_inc;
	logic [7:0] tc_q, tc_n, tc_inc, hold;
	logic [7:0] shift_q, shift_n;
	logic [7:0] rx_q, rx_n;
	logic       ackc_q, ackc_n;
	logic       ack_q, ack_n;
	logic       scl_q, scl_n;
	logic       sda_q, sda_n;
	logic       done, ignored;

	// pin levels applied when a phase begins
	function automatic logic [1:0] enter_pins(i2cm_pkg::cmd_t cmd,
		logic [i2cm_pkg::PhaseIdxW-1:0] p, logic bit7, logic ackc, logic scl, logic sda);
		logic s_c;
		logic s_d;
		s_c = scl;
		s_d = sda;
		unique case (cmd)
			i2cm_pkg::CMD_START: begin
				if (p == 5'd0) begin
					s_c = 1'b1;
					s_d = 1'b1;
				end else if (p == 5'd1) s_d = 1'b0;
				else s_c = 1'b0;
			end
			i2cm_pkg::CMD_STOP: begin
				if (p == 5'd0) s_d = 1'b0;
				else if (p == 5'd1) s_c = 1'b1;
				else s_d = 1'b1;
			end
			i2cm_pkg::CMD_WRITE: begin
				if (!p[4]) begin
					if (!p[0]) begin
						// SCL left alone ahead of the first data bit
						if (p != 5'd0) s_c = 1'b0;
						s_d = bit7;
					end else s_c = 1'b1;
				end else if (p == 5'd16) begin
					s_c = 1'b0;
					s_d = 1'b1;
				end else if (p == 5'd17) s_c = 1'b1;
				else s_c = 1'b0;
			end
			i2cm_pkg::CMD_READ: begin
				if (!p[4]) begin
					if (!p[0]) begin
						if (p == 5'd0) s_d = 1'b1;
						s_c = 1'b1;
					end else s_c = 1'b0;
				end else if (p == 5'd16) s_d = ~ackc;
				else if (p == 5'd17) s_c = 1'b1;
				else begin
					s_c = 1'b0;
					s_d = 1'b1;
				end
			end
			default: ;
		endcase
		return {s_c, s_d};
	endfunction

	always_comb begin
		cmd_n   = cmd_q;
		pi_n    = pi_q;
		tc_n    = tc_q;
		shift_n = shift_q;
		rx_n    = rx_q;
		ackc_n  = ackc_q;
		ack_n   = ack_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		done    = 1'b0;
		ignored = 1'b0;
		hold    = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
		tc_inc  = (tc_q == 8'hFF) ? tc_q : tc_q + 8'd1;
		pi_inc  = pi_q + 5'd1;
		if (cmd_q != i2cm_pkg::CMD_NONE) begin
			ignored = i2cm_pkg::is_cmd(item.op);
			if (tc_inc >= hold) begin
				// sampling on the tick that closes the phase
				unique case (cmd_q)
					i2cm_pkg::CMD_WRITE: begin
						if (!pi_q[4] && pi_q[0]) shift_n = {shift_q[6:0], 1'b0};
						else if (pi_q == 5'd17) ack_n = ~item.sda_in;
					end
					i2cm_pkg::CMD_READ: begin
						if (!pi_q[4] && !pi_q[0]) shift_n = {shift_q[6:0], item.sda_in};
						else if (pi_q == 5'd18) rx_n = shift_q;
					end
					default: ;
				endcase
				tc_n = 8'd0;
				if (pi_inc >= i2cm_pkg::phase_total(cmd_q)) begin
					cmd_n = i2cm_pkg::CMD_NONE;
					pi_n  = '0;
					done  = 1'b1;
				end else begin
					pi_n = pi_inc;
					{scl_n, sda_n} = enter_pins(cmd_q, pi_inc, shift_n[7], ackc_q, scl_q, sda_q);
				end
			end else begin
				tc_n = tc_inc;
			end
		end else if (i2cm_pkg::is_cmd(item.op)) begin
			cmd_n = item.op;
			pi_n  = '0;
			tc_n  = 8'd0;
			if (item.op == i2cm_pkg::CMD_WRITE) shift_n = item.tx_byte;
			if (item.op == i2cm_pkg::CMD_READ) begin
				shift_n = 8'd0;
				ackc_n  = item.read_ack;
			end
			{scl_n, sda_n} = enter_pins(item.op, '0, shift_n[7], ackc_n, scl_q, sda_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= i2cm_pkg::CMD_NONE;
			pi_q    <= '0;
			tc_q    <= 8'd0;
			shift_q <= 8'd0;
			rx_q    <= 8'd0;
			ackc_q  <= 1'b0;
			ack_q   <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else if (step) begin
			cmd_q   <= cmd_n;
			pi_q    <= pi_n;
			tc_q    <= tc_n;
			shift_q <= shift_n;
			rx_q    <= rx_n;
			ackc_q  <= ackc_n;
			ack_q   <= ack_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
		end
	end

	assign res.scl_release = scl_n;
	assign res.sda_release = sda_n;
	assign res.busy_res    = (cmd_n != i2cm_pkg::CMD_NONE);
	assign res.done_res    = done;
	assign res.rx_byte     = rx_n;
	assign res.ack_seen    = ack_n;
	assign res.cmd_ignored = ignored;

	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q == i2cm_pkg::CMD_NONE) |-> (pi_q == '0 && tc_q == 8'd0))
		else $error("idle with phase or tick count not cleared");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q != i2cm_pkg::CMD_NONE) |-> (pi_q < i2cm_pkg::phase_total(cmd_q)))
		else $error("phase index past end of command");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && done) |=> (cmd_q == i2cm_pkg::CMD_NONE))
		else $error("command completed but engine still busy");

endmodule

### verif/i2c_master_byte_engine_checker.sv
`timescale 1ns / 100ps

module i2c_master_byte_engine_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        item_valid,
	input  logic        item_ready,
	input  logic [2:0]  operation,
	input  logic [7:0]  tx_byte,
	input  logic        read_ack,
	input  logic        sda_in,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic        scl_release,
	input  logic        sda_release,
	input  logic        busy_res,
	input  logic        done_res,
	input  logic [7:0]  rx_byte,
	input  logic        ack_seen,
	input  logic        cmd_ignored,
	output int          fail_count,
	output int          pending,
	output int          beats_checked,
	output int          cmds_done,
	output int          cmds_dropped
);

	localparam logic [2:0] HoldAddr = 3'd0;

	// shadow of the engine
	i2cm_pkg::cmd_t                 cur_cmd;
	logic [i2cm_pkg::PhaseIdxW-1:0] ph_idx;
	logic [7:0]                     tick_cnt;
	logic [7:0]                     shifter;
	logic [7:0]                     rx_hold;
	logic [7:0]                     hold_cfg;
	logic                           ack_pick;
	logic                           ack_got;
	logic                           scl_lvl;
	logic                           sda_lvl;

	i2cm_pkg::res_t bus_state_q[$];
	int   errors = 0;
	int   n_checked = 0;
	int   n_done = 0;
	int   n_dropped = 0;

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			flag_error($sformatf("result beat %0d: %s got %0h, want %0h", n_checked, name,
				got, want));
	endtask

	// pin moves made as a phase begins
	function automatic void enter_phase();
		case (cur_cmd)
			i2cm_pkg::CMD_START: begin
				if (ph_idx == 0) begin
					sda_lvl = 1'b1;
					scl_lvl = 1'b1;
				end else if (ph_idx == 1) begin
					sda_lvl = 1'b0;
				end else begin
					scl_lvl = 1'b0;
				end
			end
			i2cm_pkg::CMD_STOP: begin
				if (ph_idx == 0) sda_lvl = 1'b0;
				else if (ph_idx == 1) scl_lvl = 1'b1;
				else sda_lvl = 1'b1;
			end
			i2cm_pkg::CMD_WRITE: begin
				if (ph_idx < 16) begin
					if (!ph_idx[0]) begin
						// SCL untouched ahead of the first data bit
						if (ph_idx != 0) scl_lvl = 1'b0;
						sda_lvl = shifter[7];
					end else begin
						scl_lvl = 1'b1;
					end
				end else if (ph_idx == 16) begin
					scl_lvl = 1'b0;
					sda_lvl = 1'b1;
				end else if (ph_idx == 17) begin
					scl_lvl = 1'b1;
				end else begin
					scl_lvl = 1'b0;
				end
			end
			i2cm_pkg::CMD_READ: begin
				if (ph_idx < 16) begin
					if (!ph_idx[0]) begin
						if (ph_idx == 0) sda_lvl = 1'b1;
						scl_lvl = 1'b1;
					end else begin
						scl_lvl = 1'b0;
					end
				end else if (ph_idx == 16) begin
					sda_lvl = ~ack_pick;
				end else if (ph_idx == 17) begin
					scl_lvl = 1'b1;
				end else begin
					scl_lvl = 1'b0;
					sda_lvl = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	// sampling on the tick that closes a phase
	function automatic void leave_phase(input logic sda);
		if (cur_cmd == i2cm_pkg::CMD_WRITE) begin
			if (ph_idx < 16 && ph_idx[0]) shifter = shifter << 1;
			else if (ph_idx == 17) ack_got = ~sda;
		end else if (cur_cmd == i2cm_pkg::CMD_READ) begin
			if (ph_idx < 16 && !ph_idx[0]) shifter = {shifter[6:0], sda};
			else if (ph_idx == 18) rx_hold = shifter;
		end
	endfunction

	function automatic i2cm_pkg::res_t engine_tick(input logic [2:0] op, input logic [7:0] tx,
		input logic ack, input logic sda);
		logic [7:0]                     hold;
		logic [i2cm_pkg::PhaseIdxW-1:0] span;
		logic                           is_command;
		logic                           done;
		logic                           dropped;
		i2cm_pkg::res_t                 r;
		hold = (hold_cfg == 8'd0) ? 8'd1 : hold_cfg;
		is_command = (op == i2cm_pkg::CMD_START) || (op == i2cm_pkg::CMD_STOP) ||
			(op == i2cm_pkg::CMD_WRITE) || (op == i2cm_pkg::CMD_READ);
		done = 1'b0;
		dropped = 1'b0;
		if (cur_cmd != i2cm_pkg::CMD_NONE) begin
			dropped = is_command;
			if (tick_cnt != 8'hFF) tick_cnt = tick_cnt + 8'd1;
			// >= so that a hold lowered mid-phase ends the phase at once
			if (tick_cnt >= hold) begin
				leave_phase(sda);
				ph_idx = ph_idx + 1'b1;
				tick_cnt = 8'd0;
				span = (cur_cmd == i2cm_pkg::CMD_WRITE || cur_cmd == i2cm_pkg::CMD_READ) ?
					i2cm_pkg::PhasesByte : i2cm_pkg::PhasesCond;
				if (ph_idx >= span) begin
					cur_cmd = i2cm_pkg::CMD_NONE;
					ph_idx = '0;
					done = 1'b1;
				end else begin
					enter_phase();
				end
			end
		end else if (is_command) begin
			cur_cmd = i2cm_pkg::cmd_t'(op);
			ph_idx = '0;
			tick_cnt = 8'd0;
			if (cur_cmd == i2cm_pkg::CMD_WRITE) shifter = tx;
			if (cur_cmd == i2cm_pkg::CMD_READ) begin
				shifter = 8'd0;
				ack_pick = ack;
			end
			enter_phase();
		end
		r.scl_release = scl_lvl;
		r.sda_release = sda_lvl;
		r.busy_res = (cur_cmd != i2cm_pkg::CMD_NONE);
		r.done_res = done;
		r.rx_byte = rx_hold;
		r.ack_seen = ack_got;
		r.cmd_ignored = dropped;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		i2cm_pkg::res_t got;
		i2cm_pkg::res_t want;
		if (!arst_n) begin
			cur_cmd = i2cm_pkg::CMD_NONE;
			ph_idx = '0;
			tick_cnt = 8'd0;
			shifter = 8'd0;
			rx_hold = 8'd0;
			hold_cfg = i2cm_pkg::PhaseTicksRst;
			ack_pick = 1'b0;
			ack_got = 1'b0;
			scl_lvl = 1'b1;
			sda_lvl = 1'b1;
			bus_state_q.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == HoldAddr)
				hold_cfg = pwdata[7:0];
			// compare before push: a result never leaves on the edge its item enters
			if (res_valid && res_ready) begin
				got = {scl_release, sda_release, busy_res, done_res, rx_byte, ack_seen,
					cmd_ignored};
				if (bus_state_q.size() == 0) begin
					flag_error("result beat with nothing outstanding");
				end else begin
					want = bus_state_q.pop_front();
					check_field("scl_release", got.scl_release, want.scl_release);
					check_field("sda_release", got.sda_release, want.sda_release);
					check_field("busy_res", got.busy_res, want.busy_res);
					check_field("done_res", got.done_res, want.done_res);
					check_field("rx_byte", got.rx_byte, want.rx_byte);
					check_field("ack_seen", got.ack_seen, want.ack_seen);
					check_field("cmd_ignored", got.cmd_ignored, want.cmd_ignored);
					n_checked++;
					if (want.done_res) n_done++;
					if (want.cmd_ignored) n_dropped++;
				end
			end
			if (item_valid && item_ready)
				bus_state_q.push_back(engine_tick(operation, tx_byte, read_ack, sda_in));
		end
		fail_count <= errors;
		pending <= bus_state_q.size();
		beats_checked <= n_checked;
		cmds_done <= n_done;
		cmds_dropped <= n_dropped;
	end

endmodule

### verif/i2c_master_byte_engine_top_tb.sv
`timescale 1ns / 100ps

module i2c_master_byte_engine_top_tb;

	localparam int CycleLimit = 400000;
	localparam int LongHoldOff = 80;
	localparam int Budget = 70;

	localparam logic [2:0] AddrPhaseTicks = 3'd0;
	localparam logic [2:0] AddrUnmapped = 3'd4;
	localparam logic [2:0] OpUnknownLo = 3'd5;
	localparam logic [2:0] OpUnknownHi = 3'd7;

	localparam int SdaLow = 0;
	localparam int SdaHigh = 1;
	localparam int SdaRand = 2;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid;
	logic        item_ready;
	logic [2:0]  operation;
	logic [7:0]  tx_byte;
	logic        read_ack;
	logic        sda_in;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic        scl_release;
	logic        sda_release;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  rx_byte;
	logic        ack_seen;
	logic        cmd_ignored;

	int fail_count;
	int pending;
	int beats_checked;
	int cmds_done;
	int cmds_dropped;

	int         snd_idle_pct = 0;
	int         rcv_idle_pct = 0;
	int         holdoff_req = 0;
	int         holdoff_seen = 0;
	int         holdoff_left = 0;
	int         item_beats = 0;
	int         cycles = 0;
	logic [7:0] hold_now;

	i2c_master_byte_engine_top u_dut (.*);

	i2c_master_byte_engine_checker u_checker (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// sink side; a hold-off request keeps ready low for a long stretch
	always @(posedge clk) begin
		if (holdoff_req != holdoff_seen) begin
			holdoff_seen <= holdoff_req;
			holdoff_left <= LongHoldOff;
			res_ready <= 1'b0;
		end else if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	task automatic drive_tick(input logic [2:0] op, input logic [7:0] tx, input logic ack,
		input logic sda);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		tx_byte <= tx;
		read_ack <= ack;
		sda_in <= sda;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		item_beats++;
	endtask

	task automatic idle_ticks(input int n, input int sda_mode, input bit noisy);
		logic [2:0] op;
		int         pick;
		logic       sda;
		repeat (n) begin
			op = i2cm_pkg::CMD_NONE;
			pick = $urandom_range(0, 99);
			if (noisy && pick < 5)
				op = 3'($urandom_range(i2cm_pkg::CMD_START, i2cm_pkg::CMD_READ));
			else if (noisy && pick < 9) op = 3'($urandom_range(OpUnknownLo, OpUnknownHi));
			sda = (sda_mode == SdaRand) ? 1'($urandom_range(0, 1)) : 1'(sda_mode);
			drive_tick(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda);
		end
	endtask

	// one command followed by exactly enough ticks to finish it, sometimes mistimed
	task automatic bus_cmd(input i2cm_pkg::cmd_t cmd, input logic [7:0] tx, input logic ack,
		input int sda_mode, input bit noisy);
		int   span;
		logic sda;
		span = ((cmd == i2cm_pkg::CMD_WRITE || cmd == i2cm_pkg::CMD_READ) ?
			i2cm_pkg::PhasesByte : i2cm_pkg::PhasesCond) *
			((hold_now == 8'd0) ? 1 : int'(hold_now));
		if (noisy && $urandom_range(0, 9) == 0) span += int'($urandom_range(0, 3)) - 1;
		sda = (sda_mode == SdaRand) ? 1'($urandom_range(0, 1)) : 1'(sda_mode);
		drive_tick(cmd, tx, ack, sda);
		idle_ticks(span, sda_mode, noisy);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic quiesce();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_hold(input logic [7:0] v);
		quiesce();
		apb_write(AddrPhaseTicks, {24'($urandom), v});
		hold_now = v;
	endtask

	task automatic random_profile(input int snd_pct, input int rcv_pct);
		int start_beats;
		bit first;
		snd_idle_pct = snd_pct;
		rcv_idle_pct <= rcv_pct;
		holdoff_req <= holdoff_req + 1;
		start_beats = item_beats;
		first = 1'b1;
		while (item_beats - start_beats < Budget) begin
			// keep offering items through the opening hold-off
			if (!first && $urandom_range(0, 2) == 0)
				set_hold(($urandom_range(0, 9) < 6) ? 8'd1 : 8'($urandom_range(0, 3)));
			first = 1'b0;
			if ($urandom_range(0, 99) < 85) begin
				bus_cmd(i2cm_pkg::CMD_START, 8'($urandom), 1'($urandom), SdaRand, 1'b1);
				repeat ($urandom_range(1, 3))
					bus_cmd($urandom_range(0, 1) ? i2cm_pkg::CMD_WRITE : i2cm_pkg::CMD_READ,
						8'($urandom), 1'($urandom), SdaRand, 1'b1);
				bus_cmd(i2cm_pkg::CMD_STOP, 8'($urandom), 1'($urandom), SdaRand, 1'b1);
			end else begin
				repeat ($urandom_range(1, 6))
					drive_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
						1'($urandom));
				idle_ticks($urandom_range(0, 40), SdaRand, 1'b1);
			end
		end
	endtask

	initial begin
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = AddrPhaseTicks;
		pwdata = 32'd0;
		item_valid = 1'b0;
		operation = i2cm_pkg::CMD_NONE;
		tx_byte = 8'd0;
		read_ack = 1'b0;
		sda_in = 1'b1;
		hold_now = i2cm_pkg::PhaseTicksRst;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unknown codes while idle, then a start at the reset hold
		for (int u = OpUnknownLo; u <= OpUnknownHi; u++) drive_tick(3'(u), 8'hFF, 1'b1, 1'b1);
		bus_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0, SdaRand, 1'b0);

		set_hold(8'd1);
		apb_write(AddrUnmapped, 32'hFFFF_FFFF);
		bus_cmd(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0, SdaLow, 1'b0);
		bus_cmd(i2cm_pkg::CMD_WRITE, 8'h00, 1'b1, SdaHigh, 1'b0);
		bus_cmd(i2cm_pkg::CMD_READ, 8'h00, 1'b1, SdaHigh, 1'b0);
		bus_cmd(i2cm_pkg::CMD_READ, 8'hFF, 1'b0, SdaLow, 1'b0);

		// dropped commands: one mid-transfer, one on the finishing tick
		drive_tick(i2cm_pkg::CMD_WRITE, 8'hA5, 1'b0, 1'b0);
		idle_ticks(3, SdaRand, 1'b0);
		drive_tick(i2cm_pkg::CMD_READ, 8'h5A, 1'b1, 1'b0);
		idle_ticks(i2cm_pkg::PhasesByte - 5, SdaRand, 1'b0);
		drive_tick(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0);
		bus_cmd(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, SdaRand, 1'b0);

		// zero hold behaves as one
		set_hold(8'd0);
		bus_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0, SdaRand, 1'b0);
		bus_cmd(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, SdaRand, 1'b0);

		// longest hold, then cut short part-way through the first phase
		set_hold(8'd255);
		drive_tick(i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b1);
		idle_ticks(10, SdaRand, 1'b0);
		set_hold(8'd2);
		idle_ticks(8, SdaRand, 1'b0);
		bus_cmd(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, SdaRand, 1'b0);

		random_profile(28, 81);
		random_profile(81, 28);
		random_profile(0, 0);

		quiesce();
		repeat (4) @(posedge clk);
		$display("Run covered %0d item beats and %0d checked result beats in %0d cycles",
			item_beats, beats_checked, cycles);
		$display("%0d commands completed, %0d dropped while busy; holds 0 to 255, %s",
			cmds_done, cmds_dropped, "both idle profiles and long sink hold-offs");
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### files.f
sv/i2cm_pkg.sv
sv/i2cm_core.sv
sv/i2c_master_byte_engine_top.sv
verif/i2c_master_byte_engine_checker.sv
verif/i2c_master_byte_engine_top_tb.sv
